// ===== hdl/wds_pkg.sv =====
// waypoint dwell sequencer: shared types, register codes and fixed-point constants
// no dependencies; used by the channel interfaces, wds_arrive and the top level
package wds_pkg;

   localparam int unsigned FIELD_W     = 16;   // packed waypoint and gain fields
   localparam int unsigned WP_W        = 48;   // three packed fields
   localparam int unsigned STICK_W     = 16;
   localparam int unsigned SWITCH_W    = 16;
   localparam int unsigned NOW_W       = 32;
   localparam int unsigned DWELL_W     = 32;
   localparam int unsigned RAD_W       = 15;
   localparam int unsigned RSQ_W       = 2 * RAD_W;
   localparam int unsigned SQSUM_W     = RSQ_W + 2;
   localparam int unsigned PROD_W      = 2 * STICK_W;
   localparam int unsigned STICK_SHIFT = 14;
   localparam int unsigned OFF_W       = PROD_W - STICK_SHIFT;
   localparam int unsigned SUM_W       = OFF_W + 2;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 48;

   // 0.6 m in Q8.12, rounded down
   localparam logic signed [SUM_W-1:0] TOOL_X_MAX = 20'sd2457;

   localparam logic [DWELL_W-1:0] DWELL_FIRST_RST  = 32'd500;
   localparam logic [DWELL_W-1:0] DWELL_SECOND_RST = 32'd1000;

   localparam logic [1:0] PHASE_NUM_A    = 2'd0;
   localparam logic [1:0] PHASE_NUM_B    = 2'd1;
   localparam logic [1:0] PHASE_NUM_C    = 2'd2;
   localparam logic [1:0] PHASE_NUM_HOLD = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WAYPOINT_A    = 3'd0,
      REG_WAYPOINT_B    = 3'd1,
      REG_WAYPOINT_C    = 3'd2,
      REG_AXIS_SCALES   = 3'd3,
      REG_TOOL_THICK    = 3'd4,
      REG_ARRIVE_RADIUS = 3'd5,
      REG_DWELL_FIRST   = 3'd6,
      REG_DWELL_SECOND  = 3'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      PH_WP_A = 4'b0001,
      PH_WP_B = 4'b0010,
      PH_WP_C = 4'b0100,
      PH_HOLD = 4'b1000
   } phase_type;

   // load strobes for the two arrival pipeline stages
   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      case (ph)
         PH_WP_A: code = PHASE_NUM_A;
         PH_WP_B: code = PHASE_NUM_B;
         PH_WP_C: code = PHASE_NUM_C;
         PH_HOLD: code = PHASE_NUM_HOLD;
         default: code = PHASE_NUM_A;
      endcase
      return code;
   endfunction

endpackage

// ===== hdl/wds_if.sv =====
// waypoint dwell sequencer: sample, result and register-write channel interfaces
// depends on wds_pkg for field widths
interface wds_req_if #(parameter int unsigned POS_WIDTH = 16);
   logic                                 valid;
   logic                                 ready;
   logic signed [POS_WIDTH-1:0]          tray_x;
   logic signed [POS_WIDTH-1:0]          tray_y;
   logic signed [POS_WIDTH-1:0]          tray_z;
   logic [wds_pkg::NOW_W-1:0]            now;
   logic signed [wds_pkg::STICK_W-1:0]   stick_x;
   logic signed [wds_pkg::STICK_W-1:0]   stick_y;
   logic signed [wds_pkg::STICK_W-1:0]   stick_z;
   logic signed [wds_pkg::SWITCH_W-1:0]  nudge_channel;
   logic signed [wds_pkg::SWITCH_W-1:0]  reset_channel;

   modport source (output valid, tray_x, tray_y, tray_z, now, stick_x, stick_y, stick_z,
                   nudge_channel, reset_channel, input ready);
   modport sink   (input valid, tray_x, tray_y, tray_z, now, stick_x, stick_y, stick_z,
                   nudge_channel, reset_channel, output ready);
endinterface

interface wds_rsp_if #(parameter int unsigned POS_WIDTH = 16);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  phase;
   logic signed [POS_WIDTH-1:0] tool_x;
   logic signed [POS_WIDTH-1:0] tool_y;
   logic signed [POS_WIDTH-1:0] tool_z;
   logic signed [POS_WIDTH-1:0] plate_x;
   logic signed [POS_WIDTH-1:0] plate_y;
   logic signed [POS_WIDTH-1:0] plate_z;

   modport source (output valid, phase, tool_x, tool_y, tool_z, plate_x, plate_y, plate_z,
                   input ready);
   modport sink   (input valid, phase, tool_x, tool_y, tool_z, plate_x, plate_y, plate_z,
                   output ready);
endinterface

interface wds_csr_if;
   logic                               valid;
   logic                               ready;
   logic [wds_pkg::CSR_INDEX_W-1:0]    index;
   logic [wds_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/wds_arrive.sv =====
// waypoint dwell sequencer: arrival test of the tray against one waypoint
// two registered stages (abs distance and squares, then sum and compare); uses wds_pkg
module wds_arrive #(
   parameter int unsigned POS_WIDTH = 16
) (
   input  logic                               clock,
   input  wds_pkg::stage_en_type              stage_en,
   input  logic signed [POS_WIDTH-1:0]        tray_x,
   input  logic signed [POS_WIDTH-1:0]        tray_y,
   input  logic signed [POS_WIDTH-1:0]        tray_z,
   input  logic [wds_pkg::WP_W-1:0]           waypoint,
   input  logic [wds_pkg::RAD_W-1:0]          radius,
   input  logic [wds_pkg::RSQ_W-1:0]          radius_sq,
   output logic                               arrived
);

   localparam int unsigned DW = ((POS_WIDTH > wds_pkg::FIELD_W) ? POS_WIDTH
                                                                : wds_pkg::FIELD_W) + 1;

   logic signed [POS_WIDTH-1:0]      tray_axis [3];
   logic [2:0]                       far_in;
   logic [2:0]                       far_ff;
   logic [wds_pkg::RSQ_W-1:0]        sq_in [3];
   logic [wds_pkg::RSQ_W-1:0]        sq_ff [3];
   logic [wds_pkg::SQSUM_W-1:0]      sum_sq;
   logic                             arrived_in;
   logic                             arrived_ff;

   assign tray_axis[0] = tray_x;
   assign tray_axis[1] = tray_y;
   assign tray_axis[2] = tray_z;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic signed [wds_pkg::FIELD_W-1:0] wp_axis;
      logic signed [DW-1:0]               diff;
      logic [DW-1:0]                      axis_dist;

      assign wp_axis   = $signed(waypoint[wds_pkg::FIELD_W*i +: wds_pkg::FIELD_W]);
      assign diff      = DW'(tray_axis[i]) - DW'(wp_axis);
      assign axis_dist = diff[DW-1] ? DW'(-diff) : DW'(diff);
      // beyond the radius on one axis means not arrived; keeps the squares narrow
      assign far_in[i] = axis_dist > DW'(radius);
      assign sq_in[i]  = axis_dist[wds_pkg::RAD_W-1:0] * axis_dist[wds_pkg::RAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         far_ff <= far_in;
         sq_ff  <= sq_in;
      end
   end

   assign sum_sq     = wds_pkg::SQSUM_W'(sq_ff[0]) + wds_pkg::SQSUM_W'(sq_ff[1])
                     + wds_pkg::SQSUM_W'(sq_ff[2]);
   assign arrived_in = ~(|far_ff) && (sum_sq < wds_pkg::SQSUM_W'(radius_sq));

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         arrived_ff <= arrived_in;
      end
   end

   assign arrived = arrived_ff;

endmodule

// ===== hdl/waypoint_dwell_sequencer_top.sv =====
// waypoint dwell sequencer top level: four-stage pipeline with sequence state
// depends on wds_pkg, wds_if (channel interfaces) and wds_arrive
//
//   channel  | dir | payload                                      | accepted when
//   req_ch   | in  | tray x/y/z, now, sticks x/y/z, nudge, reset  | valid & ready
//   rsp_ch   | out | phase, tool x/y/z, plate x/y/z               | valid & ready
//   csr_ch   | in  | register index, write data                   | valid & ready
//
// one sample per cycle while rsp_ch does not stall the pipeline
// the stages are: input register, squares and stick products, arrival compare and
// offset shift, sequence update and targets into the output register
// each stage moves on when the next one is empty or moving, so a stalled result
// only holds back stages that are full; csr_ch is always ready
// reset (synchronous) returns phase 0, clears the dwell and restores register defaults
module waypoint_dwell_sequencer_top #(
   parameter int unsigned POS_WIDTH  = 16,
   parameter int unsigned TIME_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   wds_req_if.sink    req_ch,
   wds_rsp_if.source  rsp_ch,
   wds_csr_if.sink    csr_ch
);

   localparam int unsigned SUM_W = wds_pkg::SUM_W;
   localparam int unsigned XW    = (POS_WIDTH > SUM_W) ? POS_WIDTH : SUM_W;
   localparam int unsigned NW    = (TIME_WIDTH > wds_pkg::NOW_W) ? TIME_WIDTH
                                                                 : wds_pkg::NOW_W;
   localparam logic signed [XW-1:0] POS_MAX = {{(XW-POS_WIDTH+1){1'b0}},
                                                {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [XW-1:0] POS_MIN = ~POS_MAX;

   // register file
   logic [wds_pkg::WP_W-1:0]     wp_a_ff, wp_b_ff, wp_c_ff, scales_ff;
   logic [wds_pkg::RAD_W-1:0]    thick_ff, radius_ff;
   logic [wds_pkg::DWELL_W-1:0]  dwell_first_ff, dwell_second_ff;
   logic [wds_pkg::RSQ_W-1:0]    radius_sq_ff, radius_sq_in;

   // pipeline handshake
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic ld1, ld2, ld3, ld4;
   wds_pkg::stage_en_type stage_en;

   // stage 1
   logic signed [POS_WIDTH-1:0]          tray_x_ff, tray_y_ff, tray_z_ff;
   logic [wds_pkg::NOW_W-1:0]            now1_ff;
   logic signed [wds_pkg::STICK_W-1:0]   stick1_ff [3];
   logic signed [wds_pkg::SWITCH_W-1:0]  nudge1_ff, rst_ch1_ff;

   // stage 2
   logic signed [wds_pkg::PROD_W-1:0]    prod_in [3];
   logic signed [wds_pkg::PROD_W-1:0]    prod_ff [3];
   logic [TIME_WIDTH-1:0]                now2_ff, now1_t;
   logic [NW-1:0]                        now1_ext;
   logic                                 rst_neg2_ff;

   // stage 3
   logic signed [wds_pkg::OFF_W-1:0]     off_in [3];
   logic signed [wds_pkg::OFF_W-1:0]     off_ff [3];
   logic [TIME_WIDTH-1:0]                now3_ff;
   logic                                 rst_neg3_ff;
   logic                                 arr_a, arr_b, arr_c;

   // sequence state
   wds_pkg::phase_type                   phase_ff, phase_in;
   logic                                 armed_ff, armed_in;
   logic [TIME_WIDTH-1:0]                entry_ff, entry_in;
   logic [TIME_WIDTH-1:0]                elapsed;
   logic [wds_pkg::DWELL_W-1:0]          dwell_sel;
   logic                                 arr_sel, expired;

   // targets
   logic [wds_pkg::WP_W-1:0]             wp_sel;
   logic signed [SUM_W-1:0]              base [3];
   logic signed [SUM_W-1:0]              plate_sum [3];
   logic signed [SUM_W-1:0]              tool_x_sum, tool_z_sum;
   logic signed [POS_WIDTH-1:0]          tool_x_ff, tool_y_ff, tool_z_ff;
   logic signed [POS_WIDTH-1:0]          plate_x_ff, plate_y_ff, plate_z_ff;
   logic [1:0]                           phase_out_ff;

   function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > POS_MAX) begin
         x = POS_MAX;
      end else if (x < POS_MIN) begin
         x = POS_MIN;
      end
      return x[POS_WIDTH-1:0];
   endfunction

   // ---------------- register writes ----------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_a_ff         <= '0;
         wp_b_ff         <= '0;
         wp_c_ff         <= '0;
         scales_ff       <= '0;
         thick_ff        <= '0;
         radius_ff       <= '0;
         dwell_first_ff  <= wds_pkg::DWELL_FIRST_RST;
         dwell_second_ff <= wds_pkg::DWELL_SECOND_RST;
      end else if (csr_ch.valid) begin
         case (wds_pkg::csr_reg_type'(csr_ch.index))
            wds_pkg::REG_WAYPOINT_A:    wp_a_ff         <= csr_ch.data[wds_pkg::WP_W-1:0];
            wds_pkg::REG_WAYPOINT_B:    wp_b_ff         <= csr_ch.data[wds_pkg::WP_W-1:0];
            wds_pkg::REG_WAYPOINT_C:    wp_c_ff         <= csr_ch.data[wds_pkg::WP_W-1:0];
            wds_pkg::REG_AXIS_SCALES:   scales_ff       <= csr_ch.data[wds_pkg::WP_W-1:0];
            wds_pkg::REG_TOOL_THICK:    thick_ff        <= csr_ch.data[wds_pkg::RAD_W-1:0];
            wds_pkg::REG_ARRIVE_RADIUS: radius_ff       <= csr_ch.data[wds_pkg::RAD_W-1:0];
            wds_pkg::REG_DWELL_FIRST:   dwell_first_ff  <= csr_ch.data[wds_pkg::DWELL_W-1:0];
            wds_pkg::REG_DWELL_SECOND:  dwell_second_ff <= csr_ch.data[wds_pkg::DWELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // squared radius is registered from the radius register and follows it in the next cycle
   assign radius_sq_in = radius_ff * radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= '0;
      end else begin
         radius_sq_ff <= radius_sq_in;
      end
   end

   // ---------------- pipeline control ----------------
   assign rdy4 = ~out_v_ff | rsp_ch.ready;
   assign rdy3 = ~s3_v_ff | rdy4;
   assign rdy2 = ~s2_v_ff | rdy3;
   assign rdy1 = ~s1_v_ff | rdy2;
   assign ld1  = req_ch.valid & rdy1;
   assign ld2  = s1_v_ff & rdy2;
   assign ld3  = s2_v_ff & rdy3;
   assign ld4  = s3_v_ff & rdy4;

   assign req_ch.ready = rdy1;
   assign stage_en.s2  = ld2;
   assign stage_en.s3  = ld3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_v_ff <= req_ch.valid;
         end
         if (rdy2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (rdy3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (rdy4) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   // ---------------- stage 1: input register ----------------
   always_ff @(posedge clock) begin
      if (ld1) begin
         tray_x_ff    <= req_ch.tray_x;
         tray_y_ff    <= req_ch.tray_y;
         tray_z_ff    <= req_ch.tray_z;
         now1_ff      <= req_ch.now;
         stick1_ff[0] <= req_ch.stick_x;
         stick1_ff[1] <= req_ch.stick_y;
         stick1_ff[2] <= req_ch.stick_z;
         nudge1_ff    <= req_ch.nudge_channel;
         rst_ch1_ff   <= req_ch.reset_channel;
      end
   end

   // ---------------- stage 2: stick products, squares ----------------
   assign now1_ext = NW'(now1_ff);
   assign now1_t   = now1_ext[TIME_WIDTH-1:0];

   for (genvar i = 0; i < 3; i++) begin : g_prod
      logic signed [wds_pkg::FIELD_W-1:0] scale;
      logic signed [wds_pkg::PROD_W-1:0]  prod;
      assign scale      = $signed(scales_ff[wds_pkg::FIELD_W*i +: wds_pkg::FIELD_W]);
      // signed product kept apart from the zero arm of the select
      assign prod       = stick1_ff[i] * scale;
      assign prod_in[i] = (nudge1_ff > 0) ? prod : '0;
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         prod_ff     <= prod_in;
         now2_ff     <= now1_t;
         rst_neg2_ff <= rst_ch1_ff[wds_pkg::SWITCH_W-1];
      end
   end

   wds_arrive #(.POS_WIDTH(POS_WIDTH)) u_arrive_a (
      .clock(clock), .stage_en(stage_en),
      .tray_x(tray_x_ff), .tray_y(tray_y_ff), .tray_z(tray_z_ff),
      .waypoint(wp_a_ff), .radius(radius_ff), .radius_sq(radius_sq_ff),
      .arrived(arr_a)
   );

   wds_arrive #(.POS_WIDTH(POS_WIDTH)) u_arrive_b (
      .clock(clock), .stage_en(stage_en),
      .tray_x(tray_x_ff), .tray_y(tray_y_ff), .tray_z(tray_z_ff),
      .waypoint(wp_b_ff), .radius(radius_ff), .radius_sq(radius_sq_ff),
      .arrived(arr_b)
   );

   wds_arrive #(.POS_WIDTH(POS_WIDTH)) u_arrive_c (
      .clock(clock), .stage_en(stage_en),
      .tray_x(tray_x_ff), .tray_y(tray_y_ff), .tray_z(tray_z_ff),
      .waypoint(wp_c_ff), .radius(radius_ff), .radius_sq(radius_sq_ff),
      .arrived(arr_c)
   );

   // ---------------- stage 3: floor shift of the products ----------------
   for (genvar i = 0; i < 3; i++) begin : g_off
      assign off_in[i] = wds_pkg::OFF_W'(prod_ff[i] >>> wds_pkg::STICK_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         off_ff      <= off_in;
         now3_ff     <= now2_ff;
         rst_neg3_ff <= rst_neg2_ff;
      end
   end

   // ---------------- stage 4: sequence update ----------------
   assign arr_sel   = (phase_ff == wds_pkg::PH_WP_A) ? arr_a : arr_b;
   assign dwell_sel = (phase_ff == wds_pkg::PH_WP_A) ? dwell_first_ff : dwell_second_ff;
   assign elapsed   = now3_ff - entry_ff;
   assign expired   = armed_ff && (NW'(elapsed) > NW'(dwell_sel));

   always_comb begin
      phase_in = phase_ff;
      armed_in = armed_ff;
      entry_in = entry_ff;
      case (phase_ff)
         wds_pkg::PH_WP_A, wds_pkg::PH_WP_B: begin
            if (arr_sel) begin
               if (!armed_ff) begin
                  entry_in = now3_ff;
               end
               armed_in = 1'b1;
            end
            // an expiring dwell wins over a fresh arrival
            if (expired) begin
               armed_in = 1'b0;
               phase_in = (phase_ff == wds_pkg::PH_WP_A) ? wds_pkg::PH_WP_B
                                                         : wds_pkg::PH_WP_C;
            end
         end
         wds_pkg::PH_WP_C: begin
            if (arr_c) begin
               phase_in = wds_pkg::PH_HOLD;
            end
         end
         wds_pkg::PH_HOLD: begin
            if (rst_neg3_ff) begin
               phase_in = wds_pkg::PH_WP_A;
            end
         end
         default: begin
            phase_in = wds_pkg::PH_WP_A;
            armed_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wds_pkg::PH_WP_A;
         armed_ff <= 1'b0;
         entry_ff <= '0;
      end else if (ld4) begin
         phase_ff <= phase_in;
         armed_ff <= armed_in;
         entry_ff <= entry_in;
      end
   end

   // targets follow the phase after this update
   always_comb begin
      case (phase_in)
         wds_pkg::PH_WP_A: wp_sel = wp_a_ff;
         wds_pkg::PH_WP_B: wp_sel = wp_b_ff;
         default:          wp_sel = wp_c_ff;
      endcase
   end

   for (genvar i = 0; i < 3; i++) begin : g_target
      logic signed [wds_pkg::FIELD_W-1:0] wp_axis;
      assign wp_axis      = $signed(wp_sel[wds_pkg::FIELD_W*i +: wds_pkg::FIELD_W]);
      assign base[i]      = SUM_W'(wp_axis);
      assign plate_sum[i] = base[i] + SUM_W'(off_ff[i]);
   end

   assign tool_x_sum = (plate_sum[0] > wds_pkg::TOOL_X_MAX) ? wds_pkg::TOOL_X_MAX
                                                             : plate_sum[0];
   assign tool_z_sum = plate_sum[2] - $signed(SUM_W'(thick_ff));

   always_ff @(posedge clock) begin
      if (ld4) begin
         phase_out_ff <= wds_pkg::phase_code(phase_in);
         tool_x_ff    <= sat_pos(tool_x_sum);
         tool_y_ff    <= sat_pos(plate_sum[1]);
         tool_z_ff    <= sat_pos(tool_z_sum);
         plate_x_ff   <= sat_pos(plate_sum[0]);
         plate_y_ff   <= sat_pos(plate_sum[1]);
         plate_z_ff   <= sat_pos(plate_sum[2]);
      end
   end

   assign rsp_ch.valid   = out_v_ff;
   assign rsp_ch.phase   = phase_out_ff;
   assign rsp_ch.tool_x  = tool_x_ff;
   assign rsp_ch.tool_y  = tool_y_ff;
   assign rsp_ch.tool_z  = tool_z_ff;
   assign rsp_ch.plate_x = plate_x_ff;
   assign rsp_ch.plate_y = plate_y_ff;
   assign rsp_ch.plate_z = plate_z_ff;

`ifndef ASSERT_OFF
   // a dwell is only ever armed in the two dwelling phases
   a_armed_phase : assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (phase_ff == wds_pkg::PH_WP_A || phase_ff == wds_pkg::PH_WP_B))
      else $error("dwell armed outside a dwelling phase");

   // the reported phase is the state left by the transaction just loaded
   a_phase_out : assert property (@(posedge clock) disable iff (reset)
      ld4 |=> rsp_ch.phase == wds_pkg::phase_code(phase_ff))
      else $error("output phase differs from sequence state");

   // the sequence only moves when a transaction enters the output register
   a_phase_hold : assert property (@(posedge clock) disable iff (reset)
      !ld4 |=> $stable(phase_ff) && $stable(armed_ff))
      else $error("sequence state changed without a transaction");
`endif

endmodule

// ===== sim/waypoint_dwell_sequencer_top_tb.sv =====
// testbench for waypoint_dwell_sequencer_top: directed and random samples against a
// cycle-free predictor of the phase sequence and targets; depends on wds_pkg and wds_if
`timescale 1ns / 1ps

module waypoint_dwell_sequencer_top_tb;

   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 200;
   localparam int STEP_MAX     = 40;
   localparam int THICK_W      = 15;

   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SEND_GAPS,
      PACE_RECV_STALLS,
      PACE_BOTH_GAPS
   } pace_mode_type;

   typedef struct {
      logic signed [wds_pkg::FIELD_W-1:0]  tray_x;
      logic signed [wds_pkg::FIELD_W-1:0]  tray_y;
      logic signed [wds_pkg::FIELD_W-1:0]  tray_z;
      logic [wds_pkg::NOW_W-1:0]           now;
      logic signed [wds_pkg::STICK_W-1:0]  stick_x;
      logic signed [wds_pkg::STICK_W-1:0]  stick_y;
      logic signed [wds_pkg::STICK_W-1:0]  stick_z;
      logic signed [wds_pkg::SWITCH_W-1:0] nudge_channel;
      logic signed [wds_pkg::SWITCH_W-1:0] reset_channel;
   } sample_type;

   typedef struct {
      logic [1:0]                         phase;
      logic signed [wds_pkg::FIELD_W-1:0] tool_x;
      logic signed [wds_pkg::FIELD_W-1:0] tool_y;
      logic signed [wds_pkg::FIELD_W-1:0] tool_z;
      logic signed [wds_pkg::FIELD_W-1:0] plate_x;
      logic signed [wds_pkg::FIELD_W-1:0] plate_y;
      logic signed [wds_pkg::FIELD_W-1:0] plate_z;
   } targets_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wds_req_if #(.POS_WIDTH(16)) req_ch ();
   wds_rsp_if #(.POS_WIDTH(16)) rsp_ch ();
   wds_csr_if                   csr_ch ();

   waypoint_dwell_sequencer_top #(
      .POS_WIDTH  (16),
      .TIME_WIDTH (32)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // register copies seen by the predictor
   logic [wds_pkg::WP_W-1:0]    wp_a = '0;
   logic [wds_pkg::WP_W-1:0]    wp_b = '0;
   logic [wds_pkg::WP_W-1:0]    wp_c = '0;
   logic [wds_pkg::WP_W-1:0]    gains = '0;
   logic [THICK_W-1:0]          tool_thick = '0;
   logic [wds_pkg::RAD_W-1:0]   radius = '0;
   logic [wds_pkg::DWELL_W-1:0] dwell_a = wds_pkg::DWELL_FIRST_RST;
   logic [wds_pkg::DWELL_W-1:0] dwell_b = wds_pkg::DWELL_SECOND_RST;

   // sequence state
   logic [1:0]                seq_phase = wds_pkg::PHASE_NUM_A;
   bit                        dwell_on = 1'b0;
   logic [wds_pkg::NOW_W-1:0] entry_stamp = '0;

   sample_type    sample_q [$];
   targets_type   target_q [$];
   pace_mode_type pace = PACE_STEADY;
   logic [wds_pkg::NOW_W-1:0] gen_now = '0;
   bit         hold_arm = 1'b0;
   bit         hold_taken = 1'b0;
   int         hold_left = 0;
   int         mismatches = 0;
   int         rsp_count = 0;
   int         cycle_count = 0;

   function automatic logic signed [wds_pkg::FIELD_W-1:0] wp_axis(
         logic [wds_pkg::WP_W-1:0] wp, int axis);
      return wp[axis*wds_pkg::FIELD_W +: wds_pkg::FIELD_W];
   endfunction

   function automatic logic signed [wds_pkg::FIELD_W-1:0] clamp_pos(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[wds_pkg::FIELD_W-1:0];
   endfunction

   function automatic logic [wds_pkg::WP_W-1:0] pack_point(int x, int y, int z);
      return {z[15:0], y[15:0], x[15:0]};
   endfunction

   function automatic logic [wds_pkg::WP_W-1:0] rand_point(int span);
      return pack_point($urandom_range(2 * span - 1) - span, $urandom_range(2 * span - 1) - span,
                        $urandom_range(2 * span - 1) - span);
   endfunction

   // per-axis early out keeps the squares small; same answer as the full squared test
   function automatic bit within_radius(sample_type s, logic [wds_pkg::WP_W-1:0] wp);
      longint pos [3];
      longint d, r, sum;
      pos[0] = s.tray_x;
      pos[1] = s.tray_y;
      pos[2] = s.tray_z;
      r = longint'(radius);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         d = pos[i] - longint'(wp_axis(wp, i));
         if (d < 0) d = -d;
         if (d > r) return 1'b0;
         sum += d * d;
      end
      return sum < r * r;
   endfunction

   function automatic targets_type advance_sequence(sample_type s);
      targets_type                 t;
      logic [1:0]                  prev_phase;
      bit                          prev_armed;
      logic [wds_pkg::NOW_W-1:0]   prev_entry, elapsed;
      logic [wds_pkg::DWELL_W-1:0] dwell;
      logic [wds_pkg::WP_W-1:0]    wp;
      longint                      base [3], off [3], stick [3];
      longint                      tx;
      prev_phase = seq_phase;
      prev_armed = dwell_on;
      prev_entry = entry_stamp;
      case (prev_phase)
         wds_pkg::PHASE_NUM_A, wds_pkg::PHASE_NUM_B: begin
            wp = (prev_phase == wds_pkg::PHASE_NUM_A) ? wp_a : wp_b;
            dwell = (prev_phase == wds_pkg::PHASE_NUM_A) ? dwell_a : dwell_b;
            if (within_radius(s, wp)) begin
               if (!prev_armed) entry_stamp = s.now;
               dwell_on = 1'b1;
            end
            elapsed = s.now - prev_entry;
            // expiry beats a fresh arrival in the same sample
            if (prev_armed && elapsed > dwell) begin
               dwell_on = 1'b0;
               seq_phase = (prev_phase == wds_pkg::PHASE_NUM_A) ? wds_pkg::PHASE_NUM_B
                                                                : wds_pkg::PHASE_NUM_C;
            end
         end
         wds_pkg::PHASE_NUM_C: begin
            if (within_radius(s, wp_c)) seq_phase = wds_pkg::PHASE_NUM_HOLD;
         end
         default: begin
            if (s.reset_channel < 0) seq_phase = wds_pkg::PHASE_NUM_A;
         end
      endcase

      wp = (seq_phase == wds_pkg::PHASE_NUM_A) ? wp_a
         : (seq_phase == wds_pkg::PHASE_NUM_B) ? wp_b : wp_c;
      stick[0] = s.stick_x;
      stick[1] = s.stick_y;
      stick[2] = s.stick_z;
      for (int i = 0; i < 3; i++) begin
         base[i] = wp_axis(wp, i);
         off[i] = 0;
         // arithmetic shift of a signed product rounds toward minus infinity
         if (s.nudge_channel > 0)
            off[i] = (stick[i] * longint'(wp_axis(gains, i))) >>> wds_pkg::STICK_SHIFT;
      end
      tx = base[0] + off[0];
      if (tx > longint'(wds_pkg::TOOL_X_MAX)) tx = longint'(wds_pkg::TOOL_X_MAX);
      t.phase   = seq_phase;
      t.tool_x  = clamp_pos(tx);
      t.tool_y  = clamp_pos(base[1] + off[1]);
      t.tool_z  = clamp_pos(base[2] - longint'(tool_thick) + off[2]);
      t.plate_x = clamp_pos(base[0] + off[0]);
      t.plate_y = clamp_pos(base[1] + off[1]);
      t.plate_z = clamp_pos(base[2] + off[2]);
      return t;
   endfunction

   function automatic sample_type mk_sample(int x, int y, int z, logic [wds_pkg::NOW_W-1:0] t,
                                            int sx, int sy, int sz, int nudge, int rsw);
      sample_type s;
      s.tray_x = wds_pkg::FIELD_W'(x);
      s.tray_y = wds_pkg::FIELD_W'(y);
      s.tray_z = wds_pkg::FIELD_W'(z);
      s.now = t;
      s.stick_x = wds_pkg::STICK_W'(sx);
      s.stick_y = wds_pkg::STICK_W'(sy);
      s.stick_z = wds_pkg::STICK_W'(sz);
      s.nudge_channel = wds_pkg::SWITCH_W'(nudge);
      s.reset_channel = wds_pkg::SWITCH_W'(rsw);
      return s;
   endfunction

   function automatic logic signed [wds_pkg::FIELD_W-1:0] near_axis(
         logic signed [wds_pkg::FIELD_W-1:0] center, int spread);
      longint p;
      p = longint'(center) + longint'($urandom_range(2 * spread)) - spread;
      return clamp_pos(p);
   endfunction

   // mostly samples around one of the waypoints with time moving forward, some pure noise
   function automatic sample_type random_sample();
      sample_type s;
      logic [wds_pkg::WP_W-1:0] wp;
      int pick, spread;
      s.stick_x = wds_pkg::STICK_W'($urandom);
      s.stick_y = wds_pkg::STICK_W'($urandom);
      s.stick_z = wds_pkg::STICK_W'($urandom);
      s.nudge_channel = wds_pkg::SWITCH_W'($urandom);
      s.reset_channel = wds_pkg::SWITCH_W'($urandom);
      if ($urandom_range(99) >= 20) s.reset_channel[wds_pkg::SWITCH_W-1] = 1'b0;
      pick = $urandom_range(99);
      if (pick < 12) begin
         s.tray_x = wds_pkg::FIELD_W'($urandom);
         s.tray_y = wds_pkg::FIELD_W'($urandom);
         s.tray_z = wds_pkg::FIELD_W'($urandom);
         if (pick < 3) gen_now = $urandom;
      end else begin
         case ($urandom_range(2))
            0: wp = wp_a;
            1: wp = wp_b;
            default: wp = wp_c;
         endcase
         spread = ($urandom_range(4) == 0) ? 0 : int'(radius) + int'(radius) / 4 + 1;
         s.tray_x = near_axis(wp_axis(wp, 0), spread);
         s.tray_y = near_axis(wp_axis(wp, 1), spread);
         s.tray_z = near_axis(wp_axis(wp, 2), spread);
      end
      gen_now += $urandom_range(STEP_MAX);
      s.now = gen_now;
      return s;
   endfunction

   task automatic write_csr(input wds_pkg::csr_reg_type idx,
                            input logic [wds_pkg::CSR_DATA_W-1:0] value);
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         wds_pkg::REG_WAYPOINT_A:    wp_a = value[wds_pkg::WP_W-1:0];
         wds_pkg::REG_WAYPOINT_B:    wp_b = value[wds_pkg::WP_W-1:0];
         wds_pkg::REG_WAYPOINT_C:    wp_c = value[wds_pkg::WP_W-1:0];
         wds_pkg::REG_AXIS_SCALES:   gains = value[wds_pkg::WP_W-1:0];
         wds_pkg::REG_TOOL_THICK:    tool_thick = value[THICK_W-1:0];
         wds_pkg::REG_ARRIVE_RADIUS: radius = value[wds_pkg::RAD_W-1:0];
         wds_pkg::REG_DWELL_FIRST:   dwell_a = value[wds_pkg::DWELL_W-1:0];
         wds_pkg::REG_DWELL_SECOND:  dwell_b = value[wds_pkg::DWELL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [wds_pkg::WP_W-1:0] a, b, c, g,
                              input logic [THICK_W-1:0] thick,
                              input logic [wds_pkg::RAD_W-1:0] rad,
                              input logic [wds_pkg::DWELL_W-1:0] dw1, dw2);
      write_csr(wds_pkg::REG_WAYPOINT_A, a);
      write_csr(wds_pkg::REG_WAYPOINT_B, b);
      write_csr(wds_pkg::REG_WAYPOINT_C, c);
      write_csr(wds_pkg::REG_AXIS_SCALES, g);
      write_csr(wds_pkg::REG_TOOL_THICK, wds_pkg::CSR_DATA_W'(thick));
      write_csr(wds_pkg::REG_ARRIVE_RADIUS, wds_pkg::CSR_DATA_W'(rad));
      write_csr(wds_pkg::REG_DWELL_FIRST, wds_pkg::CSR_DATA_W'(dw1));
      write_csr(wds_pkg::REG_DWELL_SECOND, wds_pkg::CSR_DATA_W'(dw2));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every sample is taken and every result is back, then let the pipe empty
   task automatic settle();
      while (sample_q.size() != 0 || req_ch.valid || target_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : sample_driver
      sample_type head;
      bit         rest;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            target_q.push_back(advance_sequence(sample_q.pop_front()));
         // a sample on offer stays until taken
         if (!(req_ch.valid && !req_ch.ready)) begin
            rest = (pace == PACE_SEND_GAPS && $urandom_range(99) < 49) ||
                   (pace == PACE_BOTH_GAPS && $urandom_range(99) < 37);
            if (sample_q.size() != 0 && !rest) begin
               head = sample_q[0];
               req_ch.tray_x        <= head.tray_x;
               req_ch.tray_y        <= head.tray_y;
               req_ch.tray_z        <= head.tray_z;
               req_ch.now           <= head.now;
               req_ch.stick_x       <= head.stick_x;
               req_ch.stick_y       <= head.stick_y;
               req_ch.stick_z       <= head.stick_z;
               req_ch.nudge_channel <= head.nudge_channel;
               req_ch.reset_channel <= head.reset_channel;
               req_ch.valid         <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_hold_off
      if (reset) begin
         hold_left <= 0;
      end else if (hold_arm && !hold_taken) begin
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : target_monitor
      targets_type got, want;
      bit          stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.phase   = rsp_ch.phase;
            got.tool_x  = rsp_ch.tool_x;
            got.tool_y  = rsp_ch.tool_y;
            got.tool_z  = rsp_ch.tool_z;
            got.plate_x = rsp_ch.plate_x;
            got.plate_y = rsp_ch.plate_y;
            got.plate_z = rsp_ch.plate_z;
            if (target_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d with no sample pending: phase %0d", rsp_count, got.phase);
            end else begin
               want = target_q.pop_front();
               if (got.phase !== want.phase || got.tool_x !== want.tool_x ||
                   got.tool_y !== want.tool_y || got.tool_z !== want.tool_z ||
                   got.plate_x !== want.plate_x || got.plate_y !== want.plate_y ||
                   got.plate_z !== want.plate_z) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d expected: phase %0d tool %0d %0d %0d plate %0d %0d %0d",
                              rsp_count, want.phase, want.tool_x, want.tool_y, want.tool_z,
                              want.plate_x, want.plate_y, want.plate_z);
                     $display("result %0d actual:   phase %0d tool %0d %0d %0d plate %0d %0d %0d",
                              rsp_count, got.phase, got.tool_x, got.tool_y, got.tool_z,
                              got.plate_x, got.plate_y, got.plate_z);
                  end
               end
            end
            rsp_count++;
         end
         stall = (pace == PACE_RECV_STALLS && $urandom_range(99) < 49) ||
                 (pace == PACE_BOTH_GAPS && $urandom_range(99) < 37);
         rsp_ch.ready <= (hold_left == 0) && !stall;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : run_control
      req_ch.valid         = 1'b0;
      req_ch.tray_x        = '0;
      req_ch.tray_y        = '0;
      req_ch.tray_z        = '0;
      req_ch.now           = '0;
      req_ch.stick_x       = '0;
      req_ch.stick_y       = '0;
      req_ch.stick_z       = '0;
      req_ch.nudge_channel = '0;
      req_ch.reset_channel = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = wds_pkg::REG_WAYPOINT_A;
      csr_ch.data          = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through all four phases with boundary cases
      load_config(pack_point(100, -200, 300), pack_point(2000, 50, -1000),
                  pack_point(3000, 3000, 500), pack_point(4096, -4096, 32767),
                  15'd100, 15'd64, 32'd10, 32'd0);
      pace <= PACE_STEADY;
      sample_q.push_back(mk_sample(-5000, 0, 0, 1000, 100, 200, 300, 0, 0));
      sample_q.push_back(mk_sample(100, -200, 300, 1000, 0, 0, 0, 0, 0));     // arms
      sample_q.push_back(mk_sample(100, -200, 300, 1005, 0, 0, 0, 0, 0));
      sample_q.push_back(mk_sample(140, -200, 300, 1010, 0, 0, 0, 0, 0));     // elapsed == dwell
      sample_q.push_back(mk_sample(-5000, 0, 0, 1011, 0, 0, 0, 0, 0));        // expires away
      sample_q.push_back(mk_sample(2000, 50, -1000, 1020, 0, 0, 0, 0, 0));
      sample_q.push_back(mk_sample(2000, 50, -1000, 1020, 0, 0, 0, 0, 0));    // rearrival kept
      sample_q.push_back(mk_sample(2000, 50, -1000, 1021, 0, 0, 0, 0, 0));    // expiry w/ arrival
      sample_q.push_back(mk_sample(3064, 3000, 500, 1030, 0, 0, 0, 0, 0));    // on the radius
      sample_q.push_back(mk_sample(3036, 3048, 500, 1031, 0, 0, 0, 0, 0));    // just inside
      sample_q.push_back(mk_sample(0, 0, 0, 1040, 500, 600, 700, 0, 0));
      sample_q.push_back(mk_sample(0, 0, 0, 1050, -32768, -32768, -32768, 32767, 1));
      sample_q.push_back(mk_sample(0, 0, 0, 1060, 32767, 32767, 32767, -32768, -1));
      sample_q.push_back(mk_sample(-32768, 32767, -32768, 1070, 32767, -32768, -1, 1, 32767));
      sample_q.push_back(mk_sample(32767, -32768, 32767, 1080, 0, 0, 0, 0, -32768));
      sample_q.push_back(mk_sample(100, -200, 300, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      sample_q.push_back(mk_sample(-5000, 0, 0, 5, 0, 0, 0, 0, 0));           // across the wrap
      sample_q.push_back(mk_sample(-5000, 0, 0, 10, 0, 0, 0, 0, 0));
      settle();

      for (int k = 1; k <= 8; k++) begin
         case (k)
            3: load_config(pack_point(32767, 32767, 32767),
                           wds_pkg::WP_W'({$urandom, $urandom}),
                           pack_point(32767, 32767, -32768), pack_point(32767, -32768, 32767),
                           15'h7FFF, 15'h7FFF, 32'd0, 32'd0);
            4: load_config(rand_point(8192), rand_point(8192), rand_point(8192), '0,
                           '0, 15'd1, 32'd0, 32'hFFFF_FFFF);
            5: load_config(rand_point(8192), rand_point(8192), rand_point(8192),
                           wds_pkg::WP_W'({$urandom, $urandom}), THICK_W'($urandom), '0,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF);
            default: load_config(rand_point(8192), rand_point(8192), rand_point(8192),
                                 wds_pkg::WP_W'({$urandom, $urandom}), THICK_W'($urandom),
                                 wds_pkg::RAD_W'($urandom_range(2000, 16)),
                                 $urandom_range(300), $urandom_range(300));
         endcase
         if (k == 6) gen_now = 32'hFFFF_FE00;
         pace <= pace_mode_type'((k - 1) % 4);
         // long receiver hold-off while samples keep coming so the pipe backs up
         if (k == 1) hold_arm <= 1'b1;
         for (int n = 0; n < RANDOM_ITEMS; n++) sample_q.push_back(random_sample());
         settle();
      end

      mismatches += target_q.size();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
